// ----- rtl/core/fpba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the fit-policy block allocator.
// Depends on nothing; fpba_ctrl and the top level in rtl/core import it.
package fpba_pkg;

  localparam int unsigned HEADER_BYTES  = 32;
  localparam int unsigned MANAGER_BYTES = 56;
  localparam int unsigned ALIGN_BYTES   = 4;
  localparam int unsigned MGR_RLEN      =
    (MANAGER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;

  localparam int unsigned SIZE_W    = 21;
  localparam int unsigned OFF_W     = 20;
  localparam int unsigned PAD_W     = 7;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [SIZE_W-1:0] ARENA_MAX = 21'd1048576;

  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] CFG_HEAP_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_FIT_POLICY   = 2'd1;
  localparam logic [1:0] CFG_ZERO_ALLOWED = 2'd2;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOINIT  = 3'd1,
    ST_LOWMEM  = 3'd2,
    ST_SIZE    = 3'd3,
    ST_BADADDR = 3'd4
  } status_e;

  // One segment table entry as stored in the RAM.
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic              busy;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  start;
  } seg_t;

  localparam int unsigned SEG_W = $bits(seg_t);

  typedef struct packed {
    logic [SIZE_W-1:0] heap_length;
    logic [1:0]        fit_policy;
    logic              zero_allowed;
  } cfg_t;

  typedef struct packed {
    action_e           action;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  block_offset;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0]    used_bytes;
    logic [CNT_OUT_W-1:0] used_blocks;
    logic [CNT_OUT_W-1:0] free_blocks;
    logic [SIZE_W-1:0]    free_bytes;
    logic [SIZE_W-1:0]    usable_size;
    logic                 in_use;
    logic [OFF_W-1:0]     payload_offset;
    status_e              status;
  } res_t;

  function automatic logic [SIZE_W:0] round_up(input logic [SIZE_W-1:0] n);
    return ({1'b0, n} + (SIZE_W+1)'(ALIGN_BYTES - 1)) / (SIZE_W+1)'(ALIGN_BYTES)
           * (SIZE_W+1)'(ALIGN_BYTES);
  endfunction

  // Split if the rest after the rounded request exceeds a header, or equals one with za.
  function automatic logic needs_split(input logic [SIZE_W-1:0] size,
                                       input logic [SIZE_W:0]   rlen,
                                       input logic              za);
    logic [SIZE_W:0] rest;
    rest = {1'b0, size} - rlen;
    return ({1'b0, size} >= rlen) &&
           ((rest > (SIZE_W+1)'(HEADER_BYTES)) ||
            ((rest == (SIZE_W+1)'(HEADER_BYTES)) && za));
  endfunction

endpackage

// ----- rtl/core/fpba_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module fpba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/fpba_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the allocator: scans, splits, merges and shifts the segment table.
// Depends on fpba_pkg and holds the table in one fpba_ram instance.
module fpba_ctrl #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpba_pkg::cfg_t cfg_i,
  input  logic           start_i,
  input  fpba_pkg::cmd_t cmd_i,
  output logic           idle_o,
  input  logic           res_ready_i,
  output logic           done_o,
  output fpba_pkg::res_t res_o
);
  import fpba_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCAN, S_FNEXT, S_DECIDE, S_WR1, S_WR2, S_SWEEP, S_RESP
  } state_e;

  state_e            state_q;
  action_e           op_q;
  logic [SIZE_W-1:0] req_q;
  logic [OFF_W-1:0]  off_q;

  logic              ready_q;
  logic [CNT_W-1:0]  total_q;
  logic [SIZE_W-1:0] free_total_q, busy_total_q;
  logic [CNT_W-1:0]  free_cnt_q, busy_cnt_q;

  logic [CNT_W-1:0]  sidx_q;
  logic              rv_q;
  logic [IDX_W-1:0]  ridx_q;
  logic              found_q;
  logic [IDX_W-1:0]  pick_q;
  seg_t              pick_e_q, prev_e_q, last_e_q;

  logic [IDX_W-1:0]  w1_addr_q, w2_addr_q;
  seg_t              w1_q, w2_q;

  logic              sw_up_q, sw_two_q, sw_pend_q, sweep_after_q;
  logic [IDX_W-1:0]  sw_src_q, sw_psrc_q;
  logic [CNT_W-1:0]  sw_cnt_q;

  status_e           status_q;
  logic [OFF_W-1:0]  poff_q;
  logic              inuse_q;
  logic [SIZE_W-1:0] usable_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [SEG_W-1:0]  ram_wdata, ram_rdata;
  seg_t              rd_e;

  logic [SIZE_W-1:0] hl_c, len_c, size0_c, sz_i_c;
  logic              mgr_split_c, cand_c, match_c, alloc_split_c;
  logic              has_next_c, mn_c, mp_c, best_worst_c;
  logic [OFF_W-1:0]  hdr_off_c;
  logic [SIZE_W:0]   rlen_c;
  logic [CNT_W-1:0]  fstart_c;

  fpba_ram #(
    .WIDTH(SEG_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_e = seg_t'(ram_rdata);

  always_comb begin
    hl_c          = (cfg_i.heap_length > ARENA_MAX) ? ARENA_MAX : cfg_i.heap_length;
    len_c         = hl_c / SIZE_W'(ALIGN_BYTES) * SIZE_W'(ALIGN_BYTES);
    size0_c       = len_c - SIZE_W'(HEADER_BYTES);
    mgr_split_c   = needs_split(size0_c, (SIZE_W+1)'(MGR_RLEN), cfg_i.zero_allowed);
    rlen_c        = round_up(req_q);
    cand_c        = !rd_e.busy && (rd_e.size >= req_q);
    hdr_off_c     = rd_e.start + OFF_W'(HEADER_BYTES);
    match_c       = (hdr_off_c == off_q);
    best_worst_c  = (cfg_i.fit_policy == FIT_BEST) || (cfg_i.fit_policy == FIT_WORST);
    alloc_split_c = needs_split(pick_e_q.size, rlen_c, cfg_i.zero_allowed);
    // In the merge step the read data holds the entry right after the freed one.
    has_next_c    = (CNT_W'(pick_q) + CNT_W'(1)) < total_q;
    mn_c          = has_next_c && !rd_e.busy;
    mp_c          = !prev_e_q.busy;
    sz_i_c        = pick_e_q.size + (mn_c ? rd_e.size + SIZE_W'(HEADER_BYTES) : '0);
    fstart_c      = CNT_W'(pick_q) + CNT_W'(1) + CNT_W'(mn_c);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_q)
      S_SCAN:  ram_raddr = sidx_q[IDX_W-1:0];
      S_FNEXT: ram_raddr = pick_q + IDX_W'(1);
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = w1_addr_q;
        ram_wdata = w1_q;
      end
      S_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = w2_addr_q;
        ram_wdata = w2_q;
      end
      S_SWEEP: begin
        ram_raddr = sw_src_q;
        if (sw_pend_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ram_waddr = sw_up_q ? sw_psrc_q + IDX_W'(1)
                              : sw_psrc_q - (sw_two_q ? IDX_W'(2) : IDX_W'(1));
        end
      end
      default: ram_raddr = '0;
    endcase
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_RESP) && res_ready_i;

  always_comb begin
    res_o.status         = status_q;
    res_o.payload_offset = poff_q;
    res_o.in_use         = inuse_q;
    res_o.usable_size    = usable_q;
    res_o.free_bytes     = free_total_q;
    res_o.free_blocks    = CNT_OUT_W'(free_cnt_q);
    res_o.used_blocks    = CNT_OUT_W'(busy_cnt_q);
    res_o.used_bytes     = busy_total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= ACT_INIT;
      req_q         <= '0;
      off_q         <= '0;
      ready_q       <= 1'b0;
      total_q       <= '0;
      free_total_q  <= '0;
      busy_total_q  <= '0;
      free_cnt_q    <= '0;
      busy_cnt_q    <= '0;
      sidx_q        <= '0;
      rv_q          <= 1'b0;
      ridx_q        <= '0;
      found_q       <= 1'b0;
      pick_q        <= '0;
      pick_e_q      <= '0;
      prev_e_q      <= '0;
      last_e_q      <= '0;
      w1_addr_q     <= '0;
      w2_addr_q     <= '0;
      w1_q          <= '0;
      w2_q          <= '0;
      sw_up_q       <= 1'b0;
      sw_two_q      <= 1'b0;
      sw_pend_q     <= 1'b0;
      sweep_after_q <= 1'b0;
      sw_src_q      <= '0;
      sw_psrc_q     <= '0;
      sw_cnt_q      <= '0;
      status_q      <= ST_OK;
      poff_q        <= '0;
      inuse_q       <= 1'b0;
      usable_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q    <= cmd_i.action;
            req_q   <= cmd_i.request_size;
            off_q   <= cmd_i.block_offset;
            state_q <= S_START;
          end
        end

        S_START: begin
          status_q      <= ST_OK;
          poff_q        <= '0;
          inuse_q       <= 1'b0;
          usable_q      <= '0;
          found_q       <= 1'b0;
          sidx_q        <= '0;
          rv_q          <= 1'b0;
          sweep_after_q <= 1'b0;
          case (op_q)
            ACT_INIT: begin
              ready_q      <= 1'b0;
              total_q      <= '0;
              free_total_q <= '0;
              busy_total_q <= '0;
              free_cnt_q   <= '0;
              busy_cnt_q   <= '0;
              state_q      <= S_RESP;
              if (len_c < SIZE_W'(MANAGER_BYTES + HEADER_BYTES)) begin
                status_q <= ST_LOWMEM;
              end else if (!mgr_split_c) begin
                status_q <= ST_SIZE;
              end else begin
                w1_addr_q       <= IDX_W'(0);
                w1_q.start      <= '0;
                w1_q.size       <= SIZE_W'(MGR_RLEN);
                w1_q.busy       <= 1'b1;
                w1_q.pad        <= PAD_W'(MGR_RLEN - MANAGER_BYTES);
                w2_addr_q       <= IDX_W'(1);
                w2_q.start      <= OFF_W'(HEADER_BYTES + MGR_RLEN);
                w2_q.size       <= size0_c - SIZE_W'(MGR_RLEN + HEADER_BYTES);
                w2_q.busy       <= 1'b0;
                w2_q.pad        <= '0;
                total_q         <= CNT_W'(2);
                busy_total_q    <= SIZE_W'(MGR_RLEN);
                busy_cnt_q      <= CNT_W'(1);
                free_total_q    <= size0_c - SIZE_W'(MGR_RLEN + HEADER_BYTES);
                free_cnt_q      <= CNT_W'(1);
                ready_q         <= 1'b1;
                state_q         <= S_WR1;
              end
            end
            ACT_ALLOC: begin
              if (!ready_q) begin
                status_q <= ST_NOINIT;
                state_q  <= S_RESP;
              end else if (req_q > free_total_q) begin
                status_q <= ST_LOWMEM;
                state_q  <= S_RESP;
              end else if ((req_q == '0) && !cfg_i.zero_allowed) begin
                status_q <= ST_SIZE;
                state_q  <= S_RESP;
              end else begin
                state_q <= S_SCAN;
              end
            end
            default: begin
              if (!ready_q) begin
                status_q <= ST_NOINIT;
                state_q  <= S_RESP;
              end else begin
                state_q <= S_SCAN;
              end
            end
          endcase
        end

        // One read issued per cycle; the entry read the cycle before is judged here.
        S_SCAN: begin
          if (sidx_q < total_q) begin
            rv_q   <= 1'b1;
            ridx_q <= sidx_q[IDX_W-1:0];
            sidx_q <= sidx_q + CNT_W'(1);
          end else begin
            rv_q <= 1'b0;
          end
          if (!rv_q && (sidx_q == total_q)) begin
            state_q <= S_DECIDE;
          end
          if (rv_q) begin
            last_e_q <= rd_e;
            if (op_q == ACT_ALLOC) begin
              if (cand_c) begin
                if (!found_q) begin
                  found_q  <= 1'b1;
                  pick_q   <= ridx_q;
                  pick_e_q <= rd_e;
                  if (!best_worst_c) begin
                    state_q <= S_DECIDE;
                  end
                end else if ((cfg_i.fit_policy == FIT_BEST) &&
                             (rd_e.size < pick_e_q.size)) begin
                  pick_q   <= ridx_q;
                  pick_e_q <= rd_e;
                end else if ((cfg_i.fit_policy == FIT_WORST) &&
                             (rd_e.size > pick_e_q.size)) begin
                  pick_q   <= ridx_q;
                  pick_e_q <= rd_e;
                end
              end
            end else if (match_c) begin
              found_q  <= 1'b1;
              pick_q   <= ridx_q;
              pick_e_q <= rd_e;
              prev_e_q <= last_e_q;
              state_q  <= (op_q == ACT_FREE) ? S_FNEXT : S_DECIDE;
            end
          end
        end

        S_FNEXT: state_q <= S_DECIDE;

        S_DECIDE: begin
          state_q <= S_RESP;
          case (op_q)
            ACT_ALLOC: begin
              if (!found_q) begin
                status_q <= ST_LOWMEM;
              end else if (alloc_split_c && (total_q >= CNT_W'(MAX_SEGMENTS))) begin
                status_q <= ST_LOWMEM;
              end else begin
                poff_q       <= pick_e_q.start + OFF_W'(HEADER_BYTES);
                busy_cnt_q   <= busy_cnt_q + CNT_W'(1);
                w2_addr_q    <= pick_q;
                w2_q.start   <= pick_e_q.start;
                w2_q.busy    <= 1'b1;
                if (alloc_split_c) begin
                  w1_addr_q    <= pick_q + IDX_W'(1);
                  w1_q.start   <= OFF_W'(pick_e_q.start + OFF_W'(HEADER_BYTES) + rlen_c);
                  w1_q.size    <= SIZE_W'(pick_e_q.size - rlen_c - (SIZE_W+1)'(HEADER_BYTES));
                  w1_q.busy    <= 1'b0;
                  w1_q.pad     <= '0;
                  w2_q.size    <= SIZE_W'(rlen_c);
                  w2_q.pad     <= PAD_W'(rlen_c - {1'b0, req_q});
                  busy_total_q <= SIZE_W'(busy_total_q + rlen_c);
                  free_total_q <= SIZE_W'(free_total_q - rlen_c - (SIZE_W+1)'(HEADER_BYTES));
                  total_q      <= total_q + CNT_W'(1);
                  sw_up_q      <= 1'b1;
                  sw_two_q     <= 1'b0;
                  sw_pend_q    <= 1'b0;
                  sw_src_q     <= IDX_W'(total_q - CNT_W'(1));
                  sw_cnt_q     <= total_q - CNT_W'(1) - CNT_W'(pick_q);
                  state_q      <= S_SWEEP;
                end else begin
                  w2_q.size    <= pick_e_q.size;
                  w2_q.pad     <= PAD_W'(pick_e_q.size - req_q);
                  busy_total_q <= busy_total_q + pick_e_q.size;
                  free_total_q <= free_total_q - pick_e_q.size;
                  free_cnt_q   <= free_cnt_q - CNT_W'(1);
                  state_q      <= S_WR2;
                end
              end
            end
            ACT_FREE: begin
              if (!found_q || (pick_q == '0) || !pick_e_q.busy) begin
                status_q <= ST_BADADDR;
              end else begin
                busy_total_q  <= busy_total_q - pick_e_q.size;
                busy_cnt_q    <= busy_cnt_q - CNT_W'(1);
                free_total_q  <= free_total_q + pick_e_q.size
                                 + (mn_c ? SIZE_W'(HEADER_BYTES) : '0)
                                 + (mp_c ? SIZE_W'(HEADER_BYTES) : '0);
                free_cnt_q    <= free_cnt_q + CNT_W'(1) - CNT_W'(mn_c) - CNT_W'(mp_c);
                total_q       <= total_q - CNT_W'(mn_c) - CNT_W'(mp_c);
                w2_q.busy     <= 1'b0;
                w2_q.pad      <= '0;
                if (mp_c) begin
                  w2_addr_q  <= pick_q - IDX_W'(1);
                  w2_q.start <= prev_e_q.start;
                  w2_q.size  <= prev_e_q.size + sz_i_c + SIZE_W'(HEADER_BYTES);
                end else begin
                  w2_addr_q  <= pick_q;
                  w2_q.start <= pick_e_q.start;
                  w2_q.size  <= sz_i_c;
                end
                sweep_after_q <= mn_c || mp_c;
                sw_up_q       <= 1'b0;
                sw_two_q      <= mn_c && mp_c;
                sw_pend_q     <= 1'b0;
                sw_src_q      <= fstart_c[IDX_W-1:0];
                sw_cnt_q      <= total_q - fstart_c;
                state_q       <= S_WR2;
              end
            end
            ACT_QUERY: begin
              if (!found_q) begin
                status_q <= ST_BADADDR;
              end else begin
                inuse_q  <= pick_e_q.busy;
                usable_q <= pick_e_q.size - SIZE_W'(pick_e_q.pad);
              end
            end
            default: status_q <= ST_OK;
          endcase
        end

        S_WR1: state_q <= S_WR2;

        S_WR2: state_q <= sweep_after_q ? S_SWEEP : S_RESP;

        // Moves entries one place up (split) or one or two places down (merge).
        S_SWEEP: begin
          if (sw_cnt_q != '0) begin
            sw_pend_q <= 1'b1;
            sw_psrc_q <= sw_src_q;
            sw_src_q  <= sw_up_q ? sw_src_q - IDX_W'(1) : sw_src_q + IDX_W'(1);
            sw_cnt_q  <= sw_cnt_q - CNT_W'(1);
          end else begin
            sw_pend_q <= 1'b0;
            if (!sw_pend_q) begin
              state_q <= sw_up_q ? S_WR1 : S_RESP;
            end
          end
        end

        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/fit_policy_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the fit-policy block allocator: stream ports, configuration
// registers and the result register. Depends on fpba_pkg and fpba_ctrl.
//
//  channel   direction  beat fields
//  s_axis    in         tuser: action; tdata: request_size, block_offset
//  m_axis    out        tdata: status .. used_bytes (see port comment)
//  cfg       in         cfg_index_i: register, cfg_data_i: value
//
// One request is worked on at a time. A successful init writes the manager and
// free entries without a scan; allocate, release and query scan the table (one table
// read per cycle), and a split or merge at entry k shifts the entries behind it.
// Reset leaves the arena uninitialized; the table needs no clearing pass.
// A stalled result sits in the output register; a new request is taken once
// the previous result has been loaded into it.
module fit_policy_block_allocator_unit #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // request_size[20:0], block_offset[40:21]
  input  logic [1:0]   s_axis_tuser,   // action[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // status[2:0], payload_offset[22:3], in_use[23],
                                       // usable_size[44:24], free_bytes[65:45],
                                       // free_blocks[72:66], used_blocks[79:73],
                                       // used_bytes[100:80]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [20:0]  cfg_data_i
);
  import fpba_pkg::*;

  cfg_t   cfg_q;
  cmd_t   cmd;
  res_t   res;
  logic   idle, done, start, res_ready;
  logic   m_valid_q;
  res_t   m_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_length  <= 21'd4096;
      cfg_q.fit_policy   <= 2'd0;
      cfg_q.zero_allowed <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEAP_LENGTH:  cfg_q.heap_length  <= cfg_data_i;
        CFG_FIT_POLICY:   cfg_q.fit_policy   <= cfg_data_i[1:0];
        CFG_ZERO_ALLOWED: cfg_q.zero_allowed <= cfg_data_i[0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready    = idle;
  assign start            = s_axis_tvalid && idle;
  assign cmd.action       = action_e'(s_axis_tuser);
  assign cmd.request_size = s_axis_tdata[20:0];
  assign cmd.block_offset = s_axis_tdata[40:21];

  assign res_ready = !m_valid_q || m_axis_tready;

  fpba_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .cmd_i      (cmd),
    .idle_o     (idle),
    .res_ready_i(res_ready),
    .done_o     (done),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else if (done) begin
      m_valid_q <= 1'b1;
      m_data_q  <= res;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_data_q};

endmodule

// ----- dv/tb_fit_policy_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the fit-policy block allocator: a segment table model
// predicts every result beat, which the monitor compares field by field.
// Depends on fpba_pkg and fit_policy_block_allocator_unit.
module tb_fit_policy_block_allocator_unit;
  import fpba_pkg::*;

  localparam int unsigned SEGS = 64;
  localparam int unsigned M20  = 32'hFFFFF;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [20:0]  cfg_data_i = '0;

  fit_policy_block_allocator_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Allocator model state and its copy of the registers.
  int unsigned seg_addr[SEGS];
  int unsigned seg_len[SEGS];
  bit          seg_taken[SEGS];
  int unsigned seg_slack[SEGS];
  int unsigned seg_cnt;
  bit          arena_up;
  int unsigned free_sum, busy_sum, free_num, busy_num;
  int unsigned len_reg = 4096;
  int unsigned fit_reg = 0;
  bit          zero_reg = 1'b0;

  cmd_t pending_cmds[$];
  res_t results_due[$];
  int unsigned errors = 0;
  int unsigned beats_checked = 0;
  int unsigned items_queued = 0;
  int unsigned ok_allocs = 0;
  int unsigned cycle_cnt = 0;
  bit          s_fire = 1'b0;
  bit          rx_hold = 1'b0;
  bit          quiet;

  function automatic int unsigned align4(int unsigned n);
    return (n + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
  endfunction

  function automatic bit split_needed(int unsigned i, int unsigned n);
    int unsigned rl, rest;
    rl = align4(n);
    if (rl > seg_len[i]) return 1'b0;
    rest = seg_len[i] - rl;
    return rest > HEADER_BYTES || (rest == HEADER_BYTES && zero_reg);
  endfunction

  function automatic bit claim_segment(int unsigned i, int unsigned n);
    int unsigned rl;
    bit split;
    rl = align4(n);
    split = split_needed(i, n);
    if (split) begin
      for (int unsigned k = seg_cnt; k > i + 1; k--) begin
        seg_addr[k]  = seg_addr[k-1];
        seg_len[k]   = seg_len[k-1];
        seg_taken[k] = seg_taken[k-1];
        seg_slack[k] = seg_slack[k-1];
      end
      seg_addr[i+1]  = (seg_addr[i] + HEADER_BYTES + rl) & M20;
      seg_len[i+1]   = seg_len[i] - rl - HEADER_BYTES;
      seg_taken[i+1] = 1'b0;
      seg_slack[i+1] = 0;
      seg_len[i]     = rl;
      seg_cnt++;
    end
    seg_taken[i] = 1'b1;
    seg_slack[i] = (seg_len[i] - n) & 32'h7f;
    return split;
  endfunction

  function automatic void drop_segment(int unsigned i);
    for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
      seg_addr[k]  = seg_addr[k+1];
      seg_len[k]   = seg_len[k+1];
      seg_taken[k] = seg_taken[k+1];
      seg_slack[k] = seg_slack[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic bit locate_payload(int unsigned off, output int unsigned idx);
    idx = 0;
    for (int unsigned i = 0; i < seg_cnt; i++)
      if (((seg_addr[i] + HEADER_BYTES) & M20) == off) begin
        idx = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic status_e format_arena();
    int unsigned len;
    len = (len_reg > ARENA_MAX) ? ARENA_MAX : len_reg;
    len = len / ALIGN_BYTES * ALIGN_BYTES;
    arena_up = 1'b0;
    seg_cnt = 0;
    free_sum = 0; busy_sum = 0; free_num = 0; busy_num = 0;
    if (len < MANAGER_BYTES + HEADER_BYTES) return ST_LOWMEM;
    seg_addr[0] = 0;
    seg_len[0] = len - HEADER_BYTES;
    seg_taken[0] = 1'b0;
    seg_slack[0] = 0;
    seg_cnt = 1;
    if (!split_needed(0, MANAGER_BYTES)) begin
      seg_cnt = 0;
      return ST_SIZE;
    end
    void'(claim_segment(0, MANAGER_BYTES));
    busy_sum = seg_len[0];
    busy_num = 1;
    free_sum = seg_len[1];
    free_num = 1;
    arena_up = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_e allocate_block(int unsigned n, output int unsigned off);
    int unsigned pick;
    bit found;
    pick = 0;
    found = 1'b0;
    off = 0;
    if (!arena_up) return ST_NOINIT;
    if (n > free_sum) return ST_LOWMEM;
    if (n == 0 && !zero_reg) return ST_SIZE;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (seg_taken[i] || seg_len[i] < n) continue;
      if (!found) begin
        found = 1'b1;
        pick = i;
        if (fit_reg != FIT_BEST && fit_reg != FIT_WORST) break;
      end else if (fit_reg == FIT_BEST && seg_len[i] < seg_len[pick]) begin
        pick = i;
      end else if (fit_reg == FIT_WORST && seg_len[i] > seg_len[pick]) begin
        pick = i;
      end
    end
    if (!found) return ST_LOWMEM;
    if (split_needed(pick, n) && seg_cnt >= SEGS) return ST_LOWMEM;
    if (claim_segment(pick, n)) begin
      free_sum -= seg_len[pick] + HEADER_BYTES;
    end else begin
      free_sum -= seg_len[pick];
      free_num--;
    end
    busy_sum += seg_len[pick];
    busy_num++;
    off = (seg_addr[pick] + HEADER_BYTES) & M20;
    return ST_OK;
  endfunction

  function automatic status_e release_block(int unsigned off);
    int unsigned i;
    if (!arena_up) return ST_NOINIT;
    if (!locate_payload(off, i) || i == 0 || !seg_taken[i]) return ST_BADADDR;
    seg_taken[i] = 1'b0;
    seg_slack[i] = 0;
    busy_sum -= seg_len[i];
    busy_num--;
    free_sum += seg_len[i];
    free_num++;
    if (i + 1 < seg_cnt && !seg_taken[i+1]) begin
      seg_len[i] += seg_len[i+1] + HEADER_BYTES;
      drop_segment(i + 1);
      free_sum += HEADER_BYTES;
      free_num--;
    end
    if (!seg_taken[i-1]) begin
      seg_len[i-1] += seg_len[i] + HEADER_BYTES;
      drop_segment(i);
      free_sum += HEADER_BYTES;
      free_num--;
    end
    return ST_OK;
  endfunction

  function automatic res_t predict_response(cmd_t c);
    res_t r;
    int unsigned poff, idx, usable;
    status_e st;
    r = '0;
    poff = 0;
    case (c.action)
      ACT_INIT:  st = format_arena();
      ACT_ALLOC: st = allocate_block(c.request_size, poff);
      ACT_FREE:  st = release_block(c.block_offset);
      default: begin
        if (!arena_up) st = ST_NOINIT;
        else if (!locate_payload(c.block_offset, idx)) st = ST_BADADDR;
        else begin
          st = ST_OK;
          usable = seg_len[idx] - seg_slack[idx];
          r.in_use = seg_taken[idx];
          r.usable_size = usable[20:0];
        end
      end
    endcase
    if (c.action == ACT_ALLOC && st == ST_OK) ok_allocs++;
    r.status = st;
    r.payload_offset = poff[19:0];
    r.free_bytes = free_sum[20:0];
    r.free_blocks = free_num[6:0];
    r.used_blocks = busy_num[6:0];
    r.used_bytes = busy_sum[20:0];
    return r;
  endfunction

  task automatic enqueue(action_e act, int unsigned req, int unsigned off);
    cmd_t c;
    c.action = act;
    c.request_size = req[20:0];
    c.block_offset = off[19:0];
    results_due.push_back(predict_response(c));
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  task automatic settle();
    while (pending_cmds.size() != 0 || results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[20:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HEAP_LENGTH: len_reg = val & 32'h1FFFFF;
      CFG_FIT_POLICY:  fit_reg = val & 3;
      default:         zero_reg = val[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Payload offset of a live segment, or of any segment when any_seg is set.
  function automatic int unsigned pick_offset(bit any_seg);
    int unsigned cand[$];
    for (int unsigned i = 0; i < seg_cnt; i++)
      if (any_seg || (i != 0 && seg_taken[i])) cand.push_back((seg_addr[i] + HEADER_BYTES) & M20);
    if (cand.size() == 0) return $urandom & M20;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic random_item();
    int unsigned r, sz, off;
    r = $urandom_range(0, 99);
    sz = $urandom_range(0, 1048576);
    off = $urandom & M20;
    if (r < 45) begin
      r = $urandom_range(0, 99);
      if (r < 70) sz = $urandom_range(0, 120);
      else if (r < 88) sz = $urandom_range(0, free_sum);
      else if (r < 96) sz = $urandom_range(0, 1048576);
      else sz = 1048576;
      enqueue(ACT_ALLOC, sz, off);
    end else if (r < 78) begin
      if ($urandom_range(0, 99) < 85) off = pick_offset(1'b0);
      enqueue(ACT_FREE, sz, off);
    end else if (r < 97) begin
      if ($urandom_range(0, 99) < 75) off = pick_offset(1'b1);
      enqueue(ACT_QUERY, sz, off);
    end else begin
      enqueue(ACT_INIT, sz, off);
    end
  endtask

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_checked, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    s_fire <= s_axis_tvalid && s_axis_tready;
  end

  assign quiet = cycle_cnt >= 30000 && cycle_cnt < 60000;

  // Request driver: a beat is held until taken, then the next one is offered.
  always @(negedge clk_i) begin
    bit v;
    v = s_axis_tvalid;
    if (s_fire) begin
      void'(pending_cmds.pop_front());
      v = 1'b0;
    end
    if (!v && rst_ni && pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= 18))
      v = 1'b1;
    if (v) begin
      s_axis_tdata <= {7'b0, pending_cmds[0].block_offset, pending_cmds[0].request_size};
      s_axis_tuser <= pending_cmds[0].action;
    end
    s_axis_tvalid <= v;
  end

  always @(negedge clk_i)
    m_axis_tready <= rst_ni && !rx_hold && (quiet || $urandom_range(0, 99) >= 18);

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[100:0]);
      if (results_due.size() == 0) begin
        $display("MISMATCH unexpected result beat, status %0d", got.status);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.payload_offset !== want.payload_offset)
          report_mismatch("payload_offset", got.payload_offset, want.payload_offset);
        if (got.in_use !== want.in_use) report_mismatch("in_use", got.in_use, want.in_use);
        if (got.usable_size !== want.usable_size)
          report_mismatch("usable_size", got.usable_size, want.usable_size);
        if (got.free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", got.free_bytes, want.free_bytes);
        if (got.free_blocks !== want.free_blocks)
          report_mismatch("free_blocks", got.free_blocks, want.free_blocks);
        if (got.used_blocks !== want.used_blocks)
          report_mismatch("used_blocks", got.used_blocks, want.used_blocks);
        if (got.used_bytes !== want.used_bytes)
          report_mismatch("used_bytes", got.used_bytes, want.used_bytes);
      end
      beats_checked++;
    end
  end

  // Long receiver stall so the block backs up onto its request port.
  initial begin
    int unsigned n;
    n = 0;
    while (cycle_cnt < 3000) @(posedge clk_i);
    rx_hold = 1'b1;
    while (n < 500) begin
      @(posedge clk_i);
      n++;
    end
    rx_hold = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("fit_policy_block_allocator_unit verification failed");
    $finish;
  end

  initial begin
    int unsigned lens[7] = '{4096, 1024, 1500, 8192, 700, 1048576, 2097151};
    int unsigned fits[7] = '{0, 1, 2, 3, 1, 2, 0};
    bit          zeros[7] = '{0, 1, 0, 1, 1, 0, 1};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Everything is refused before the arena is formatted.
    enqueue(ACT_ALLOC, 5, 0);
    enqueue(ACT_FREE, 0, 32);
    enqueue(ACT_QUERY, 0, 32);
    settle();
    write_reg(CFG_HEAP_LENGTH, 0);
    enqueue(ACT_INIT, 0, 0);
    settle();
    // Arena exactly manager plus header: the manager cannot be split off.
    write_reg(CFG_HEAP_LENGTH, 88);
    enqueue(ACT_INIT, 0, 0);
    settle();
    // Remainder of exactly one header only splits when zero sizes are allowed.
    write_reg(CFG_HEAP_LENGTH, 121);
    enqueue(ACT_INIT, 0, 0);
    settle();
    write_reg(CFG_ZERO_ALLOWED, 1);
    enqueue(ACT_INIT, 0, 0);
    enqueue(ACT_ALLOC, 0, 0);
    enqueue(ACT_QUERY, 0, 120);
    enqueue(ACT_FREE, 0, 120);
    settle();
    // Oversized length is clamped; a zero-size segment at the arena end wraps to offset 0.
    write_reg(CFG_HEAP_LENGTH, 2097151);
    enqueue(ACT_INIT, 0, 0);
    enqueue(ACT_ALLOC, 1048576, 0);
    enqueue(ACT_ALLOC, 1048424, 0);
    enqueue(ACT_ALLOC, 0, 0);
    enqueue(ACT_QUERY, 0, 0);
    enqueue(ACT_QUERY, 0, 32);
    enqueue(ACT_FREE, 0, 32);
    enqueue(ACT_FREE, 0, M20);
    enqueue(ACT_QUERY, 0, 1);
    enqueue(ACT_FREE, 0, 120);
    enqueue(ACT_FREE, 0, 120);
    enqueue(ACT_FREE, 0, 0);
    settle();
    write_reg(CFG_ZERO_ALLOWED, 0);
    enqueue(ACT_ALLOC, 0, 0);

    foreach (lens[p]) begin
      settle();
      write_reg(CFG_HEAP_LENGTH, lens[p]);
      write_reg(CFG_FIT_POLICY, fits[p]);
      write_reg(CFG_ZERO_ALLOWED, zeros[p]);
      enqueue(ACT_INIT, 0, 0);
      repeat (270) random_item();
    end

    settle();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d requests over 7 register settings, %0d allocations succeeded.",
             items_queued, ok_allocs);
    $display("Checked %0d result beats, %0d mismatches.", beats_checked, errors);
    if (errors == 0 && results_due.size() == 0)
      $display("fit_policy_block_allocator_unit verification clean");
    else
      $display("fit_policy_block_allocator_unit verification failed");
    $finish;
  end

endmodule
